// ===== src/spt_pkg.sv =====
// Shared types and constants for the start-of-frame locked PLL tuner.
package spt_pkg;

    localparam int INITIAL_NUMERATOR = 128;
    localparam int FRAC_BITS         = 16;

    localparam int NUM_W   = 8 + FRAC_BITS;       // numerator in fixed point
    localparam int SUM_W   = 34;                  // numerator plus signed 32-bit step
    localparam int ERR_W   = 17;                  // target minus 16-bit cycle step
    localparam int DER_W   = ERR_W + 1;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W = 4;

    localparam logic [NUM_W-1:0] NUM_INIT = NUM_W'(INITIAL_NUMERATOR) << FRAC_BITS;
    localparam logic [NUM_W-1:0] NUM_TOP  = NUM_W'(255) << FRAC_BITS;
    localparam logic [NUM_W-1:0] NUM_HALF = NUM_W'(1) << (FRAC_BITS - 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_LO  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_HI  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONTIME_LO = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONTIME_HI = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 4'd7;

    // class of a word; the codes equal the reported status
    typedef enum logic [1:0] {
        CLS_RESET  = 2'd0,
        CLS_HOLD   = 2'd1,
        CLS_UPDATE = 2'd2
    } t_cls;

    typedef struct packed {
        logic        [15:0] target;
        logic        [31:0] valid_lo;
        logic        [31:0] valid_hi;
        logic        [31:0] ontime_lo;
        logic        [31:0] ontime_hi;
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        target:    16'd3072,
        valid_lo:  32'd11875,
        valid_hi:  32'd13125,
        ontime_lo: 32'd12463,
        ontime_hi: 32'd12537,
        gain_p:    16'sd6553,
        gain_i:    16'sd6,
        gain_d:    16'sd0
    };

    typedef struct packed {
        t_cls                    cls;
        logic signed [ERR_W-1:0] err;
    } t_qent;

endpackage

// ===== src/spt_front.sv =====
// Front end: takes stamps, forms step differences and classifies each word.
module spt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spt_pkg::t_cfg       i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [31:0]         i_ref_time,
    input  logic [15:0]         i_clock_count,
    input  logic                i_q_full,
    output logic                o_push,
    output spt_pkg::t_qent      o_ent
);
    import spt_pkg::*;

    logic [31:0] r_prev_ref;
    logic [15:0] r_prev_cnt;
    logic [31:0] w_dt;
    logic [15:0] w_dc;
    logic        w_valid;
    logic        w_ontime;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    assign w_dt     = i_ref_time - r_prev_ref;
    assign w_dc     = i_clock_count - r_prev_cnt;
    assign w_valid  = (w_dt >= i_cfg.valid_lo) && (w_dt <= i_cfg.valid_hi);
    assign w_ontime = (w_dt >= i_cfg.ontime_lo) && (w_dt <= i_cfg.ontime_hi);

    always_comb begin
        o_ent.err = $signed({1'b0, i_cfg.target}) - $signed({1'b0, w_dc});
        priority if (!w_valid) begin
            o_ent.cls = CLS_RESET;
        end else if (w_ontime) begin
            o_ent.cls = CLS_UPDATE;
        end else begin
            o_ent.cls = CLS_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ref <= '0;
            r_prev_cnt <= '0;
        end else if (o_push) begin
            r_prev_ref <= i_ref_time;
            r_prev_cnt <= i_clock_count;
        end
    end

endmodule

// ===== src/spt_queue.sv =====
// Short FIFO between the classifier and the PID pipeline.
module spt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  spt_pkg::t_qent i_ent,
    input  logic           i_pop,
    output spt_pkg::t_qent o_ent,
    output logic           o_empty,
    output logic           o_full
);
    import spt_pkg::*;

    t_qent              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wp;
    logic [QPTR_W-1:0]  r_rp;
    logic [QCNT_W-1:0]  r_cnt;
    logic               w_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_ent   = r_mem[r_rp];
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(w_pop);
        end
    end

endmodule

// ===== src/spt_back.sv =====
// Back end: integrator, PID products, numerator update and output register.
module spt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spt_pkg::t_cfg  i_cfg,
    input  spt_pkg::t_qent i_ent,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_status,
    output logic [7:0]     o_pll_numerator
);
    import spt_pkg::*;

    logic                    w_adv;
    // loop state
    logic [31:0]             r_err_sum;
    logic signed [ERR_W-1:0] r_prev_err;
    logic [NUM_W-1:0]        r_num;
    // stage 1: integrator
    logic                    r_s1_v;
    t_cls                    r_s1_cls;
    logic signed [ERR_W-1:0] r_s1_err;
    logic signed [31:0]      r_s1_sum;
    logic signed [DER_W-1:0] r_s1_der;
    // stage 2: products
    logic                    r_s2_v;
    t_cls                    r_s2_cls;
    logic [31:0]             r_s2_pp;
    logic [31:0]             r_s2_ip;
    logic [31:0]             r_s2_dp;
    // stage 3: controller output
    logic                    r_s3_v;
    t_cls                    r_s3_cls;
    logic [31:0]             r_s3_out;
    // output register
    logic                    r_out_v;
    logic [1:0]              r_out_status;
    logic [7:0]              r_out_num;

    logic [31:0]             w_err32;
    logic [31:0]             n_err_sum;
    logic signed [32:0]      w_pp;
    logic signed [47:0]      w_ip;
    logic signed [33:0]      w_dp;
    logic signed [SUM_W-1:0] w_sum;
    logic [NUM_W-1:0]        w_clamp;
    logic [NUM_W-1:0]        n_num;
    logic [NUM_W-1:0]        w_rnd;

    // whole pipeline moves unless the output word is stalled
    assign w_adv = !r_out_v || i_ready;
    assign o_pop = w_adv && !i_empty;

    assign w_err32   = 32'(i_ent.err);
    assign n_err_sum = r_err_sum + w_err32;

    assign w_pp = 33'(i_cfg.gain_p) * 33'(r_s1_err);
    assign w_ip = 48'(i_cfg.gain_i) * 48'(r_s1_sum);
    assign w_dp = 34'(i_cfg.gain_d) * 34'(r_s1_der);

    assign w_sum = $signed({{(SUM_W-NUM_W){1'b0}}, r_num}) + SUM_W'($signed(r_s3_out));

    always_comb begin
        priority if (w_sum < 0) begin
            w_clamp = '0;
        end else if (w_sum > $signed({{(SUM_W-NUM_W){1'b0}}, NUM_TOP})) begin
            w_clamp = NUM_TOP;
        end else begin
            w_clamp = w_sum[NUM_W-1:0];
        end
        n_num = (r_s3_v && r_s3_cls == CLS_UPDATE) ? w_clamp : r_num;
        w_rnd = n_num + NUM_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_sum  <= '0;
            r_prev_err <= '0;
            r_num      <= NUM_INIT;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_s3_v     <= 1'b0;
            r_out_v    <= 1'b0;
        end else if (w_adv) begin
            r_s1_v  <= !i_empty;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_out_v <= r_s3_v;
            r_num   <= n_num;
            if (!i_empty) begin
                unique case (i_ent.cls)
                    CLS_RESET: begin
                        r_err_sum  <= '0;
                        r_prev_err <= '0;
                    end
                    CLS_HOLD: begin
                        r_err_sum <= n_err_sum;
                    end
                    CLS_UPDATE: begin
                        r_err_sum  <= n_err_sum;
                        r_prev_err <= i_ent.err;
                    end
                    default: begin
                        r_err_sum <= r_err_sum;
                    end
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_cls     <= i_ent.cls;
            r_s1_err     <= i_ent.err;
            r_s1_sum     <= $signed(n_err_sum);
            r_s1_der     <= DER_W'(i_ent.err) - DER_W'(r_prev_err);
            r_s2_cls     <= r_s1_cls;
            r_s2_pp      <= w_pp[31:0];
            r_s2_ip      <= w_ip[31:0];
            r_s2_dp      <= w_dp[31:0];
            r_s3_cls     <= r_s2_cls;
            r_s3_out     <= r_s2_pp + r_s2_ip + r_s2_dp;
            r_out_status <= r_s3_cls;
            r_out_num    <= w_rnd[NUM_W-1:FRAC_BITS];
        end
    end

    assign o_valid         = r_out_v;
    assign o_status        = r_out_status;
    assign o_pll_numerator = r_out_num;

endmodule

// ===== src/sof_locked_pll_pid_tuner_top.sv =====
// Top level of the start-of-frame locked PLL tuner: config registers and wiring.
//
//   channel   handshake            word
//   -------   ------------------   -----------------------------------
//   in        i_valid / o_ready    i_ref_time, i_clock_count
//   out       o_valid / i_ready    o_status, o_pll_numerator
//   config    i_cfg_we             i_cfg_idx, i_cfg_data
//
// One word per cycle sustained while the output is not stalled. From accept to
// o_valid with an empty queue a word passes the queue, then the integrator, product
// and sum stages into the numerator/output register. The clamp loop closes there.
// Synchronous active-low reset clears the queue, pipeline and loop state.
// An output stall freezes the pipeline; the 4-word queue keeps o_ready high
// until it fills.
module sof_locked_pll_pid_tuner_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [spt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [31:0]                   i_ref_time,
    input  logic [15:0]                   i_clock_count,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic [7:0]                    o_pll_numerator
);
    import spt_pkg::*;

    t_cfg  r_cfg;
    t_qent w_push_ent;
    t_qent w_head_ent;
    logic  w_push;
    logic  w_pop;
    logic  w_empty;
    logic  w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET:    r_cfg.target    <= i_cfg_data[15:0];
                CFG_VALID_LO:  r_cfg.valid_lo  <= i_cfg_data;
                CFG_VALID_HI:  r_cfg.valid_hi  <= i_cfg_data;
                CFG_ONTIME_LO: r_cfg.ontime_lo <= i_cfg_data;
                CFG_ONTIME_HI: r_cfg.ontime_hi <= i_cfg_data;
                CFG_GAIN_P:    r_cfg.gain_p    <= $signed(i_cfg_data[15:0]);
                CFG_GAIN_I:    r_cfg.gain_i    <= $signed(i_cfg_data[15:0]);
                CFG_GAIN_D:    r_cfg.gain_d    <= $signed(i_cfg_data[15:0]);
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    spt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_ref_time    (i_ref_time),
        .i_clock_count (i_clock_count),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_ent         (w_push_ent)
    );

    spt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ent   (w_push_ent),
        .i_pop   (w_pop),
        .o_ent   (w_head_ent),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    spt_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_ent           (w_head_ent),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_pll_numerator (o_pll_numerator)
    );

endmodule

// ===== src/spt_checker.sv =====
// Port-level checks for the PLL tuner top level, bound to it.
module spt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [31:0] i_ref_time,
    input logic [15:0] i_clock_count,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [7:0]  o_pll_numerator
);

    // a waiting input word holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_ref_time) && $stable(i_clock_count))
        else $error("input word changed while waiting");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_pll_numerator))
        else $error("output word changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3)
        else $error("undefined status code");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready)
        else $error("not ready after reset");

endmodule

bind sof_locked_pll_pid_tuner_top spt_checker u_spt_checker (.*);

// ===== sim/sof_locked_pll_pid_tuner_chk.sv =====
// Result checker for the PLL tuner: tracks config writes, predicts each word, compares outputs.
`timescale 1ns / 100ps
module sof_locked_pll_pid_tuner_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [spt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [31:0]                   i_ref_time,
    input  logic [15:0]                   i_clock_count,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [1:0]                    i_status,
    input  logic [7:0]                    i_pll_numerator,
    output int                            o_fail_cnt,
    output int                            o_owed
);
    import spt_pkg::*;

    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        t_cls       status;
        logic [7:0] numer;
    } t_tuner_word;

    t_cfg        regs;
    logic [31:0] last_stamp;
    logic [15:0] last_cycles;
    logic [31:0] last_err;
    logic [31:0] err_acc;
    logic [31:0] numer_q;
    t_tuner_word owed_q[$];
    int          reports = 0;

    // One control-loop update per start-of-frame event.
    function automatic t_tuner_word advance_loop(input logic [31:0] stamp,
                                                 input logic [15:0] cycles);
        logic [31:0]        dt, err, deriv, drive, gp, gi, gd, rounded;
        logic [15:0]        dc;
        logic signed [63:0] nxt;
        logic               in_window, in_time;
        t_tuner_word        w;
        dt        = stamp - last_stamp;
        dc        = cycles - last_cycles;
        in_window = dt >= regs.valid_lo && dt <= regs.valid_hi;
        in_time   = dt >= regs.ontime_lo && dt <= regs.ontime_hi;
        last_stamp  = stamp;
        last_cycles = cycles;
        if (!in_window) begin
            last_err = '0;
            err_acc  = '0;
            w.status = CLS_RESET;
        end else begin
            err     = {16'd0, regs.target} - {16'd0, dc};
            err_acc = err_acc + err;
            if (in_time) begin
                deriv    = err - last_err;
                last_err = err;
                gp = {{16{regs.gain_p[15]}}, regs.gain_p};
                gi = {{16{regs.gain_i[15]}}, regs.gain_i};
                gd = {{16{regs.gain_d[15]}}, regs.gain_d};
                // low 32 bits of each product and of the sum, read as signed
                drive = gp * err + gi * err_acc + gd * deriv;
                nxt   = $signed({32'd0, numer_q}) + $signed({{32{drive[31]}}, drive});
                if (nxt > $signed(64'(NUM_TOP)))
                    numer_q = 32'(NUM_TOP);
                else if (nxt < 0)
                    numer_q = '0;
                else
                    numer_q = nxt[31:0];
                w.status = CLS_UPDATE;
            end else begin
                w.status = CLS_HOLD;
            end
        end
        rounded = numer_q + (32'd1 << (FRAC_BITS - 1));
        w.numer = rounded[FRAC_BITS +: 8];
        return w;
    endfunction

    task automatic flag(input string field, input int want, input int got);
        if (reports < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        reports++;
        o_fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_tuner_word want;
        if (!i_rst_n) begin
            regs        = CFG_RESET;
            last_stamp  = '0;
            last_cycles = '0;
            last_err    = '0;
            err_acc     = '0;
            numer_q     = 32'(NUM_INIT);
            owed_q.delete();
        end else begin
            // compare before pushing so a stray word cannot match a fresh prediction
            if (i_out_valid && i_out_ready) begin
                if (owed_q.size() == 0) begin
                    flag("unexpected word, status", -1, i_status);
                end else begin
                    want = owed_q.pop_front();
                    if (want.status != i_status)
                        flag("status", want.status, i_status);
                    if (want.numer != i_pll_numerator)
                        flag("pll_numerator", want.numer, i_pll_numerator);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TARGET:    regs.target    = i_cfg_data[15:0];
                    CFG_VALID_LO:  regs.valid_lo  = i_cfg_data;
                    CFG_VALID_HI:  regs.valid_hi  = i_cfg_data;
                    CFG_ONTIME_LO: regs.ontime_lo = i_cfg_data;
                    CFG_ONTIME_HI: regs.ontime_hi = i_cfg_data;
                    CFG_GAIN_P:    regs.gain_p    = i_cfg_data[15:0];
                    CFG_GAIN_I:    regs.gain_i    = i_cfg_data[15:0];
                    CFG_GAIN_D:    regs.gain_d    = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                owed_q.push_back(advance_loop(i_ref_time, i_clock_count));
        end
        o_owed = owed_q.size();
    end

endmodule

// ===== sim/sof_locked_pll_pid_tuner_top_tb.sv =====
// Testbench top for the PLL tuner: clock, reset, event stimulus, config phases and verdict.
`timescale 1ns / 100ps
module sof_locked_pll_pid_tuner_top_tb;
    import spt_pkg::*;

    localparam int LIMIT   = 600000;
    localparam int RX_HOLD = 300;
    localparam int SETTLE  = 10;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [31:0]          i_cfg_data    = '0;
    logic                 i_valid       = 1'b0;
    logic [31:0]          i_ref_time    = '0;
    logic [15:0]          i_clock_count = '0;
    logic                 i_ready       = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic [1:0]           o_status;
    logic [7:0]           o_pll_numerator;

    int          fail_cnt;
    int          owed;
    int          cycle_cnt  = 0;
    int          hold_reqs  = 0;
    bit          tx_gapless = 1'b0;
    t_cfg        regs_now   = CFG_RESET;
    logic [31:0] last_t     = '0;
    logic [15:0] last_c     = '0;

    sof_locked_pll_pid_tuner_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_ref_time      (i_ref_time),
        .i_clock_count   (i_clock_count),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_pll_numerator (o_pll_numerator)
    );

    sof_locked_pll_pid_tuner_chk u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_ref_time      (i_ref_time),
        .i_clock_count   (i_clock_count),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_status        (o_status),
        .i_pll_numerator (o_pll_numerator),
        .o_fail_cnt      (fail_cnt),
        .o_owed          (owed)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT) begin
            $display("sof_locked_pll_pid_tuner_top_tb NOT OK");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 70)
            return $urandom_range(3, 1);
        if (r < 95)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic send_word(input logic [31:0] stamp, input logic [15:0] cycles);
        i_valid       <= 1'b1;
        i_ref_time    <= stamp;
        i_clock_count <= cycles;
        last_t = stamp;
        last_c = cycles;
        do @(posedge i_clk); while (!o_ready);
        if (!tx_gapless && $urandom_range(2, 0) == 0) begin
            i_valid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
    endtask

    task automatic send_step(input logic [31:0] dt, input logic [15:0] dc);
        send_word(last_t + dt, last_c + dc);
    endtask

    // Mostly steps inside the current windows with a cycle count near target,
    // plus window edges, off-window steps and raw noise.
    task automatic send_frame_event();
        int unsigned pick, spread;
        logic [31:0] dt;
        logic [15:0] dc;
        pick = $urandom_range(99, 0);
        if (pick < 8) begin
            send_word($urandom, 16'($urandom));
            return;
        end
        if (pick < 55 && regs_now.ontime_lo <= regs_now.ontime_hi)
            dt = $urandom_range(regs_now.ontime_hi, regs_now.ontime_lo);
        else if (pick < 78 && regs_now.valid_lo <= regs_now.valid_hi)
            dt = $urandom_range(regs_now.valid_hi, regs_now.valid_lo);
        else if (pick < 92) begin
            case ($urandom_range(7, 0))
                0:       dt = regs_now.valid_lo;
                1:       dt = regs_now.valid_hi;
                2:       dt = regs_now.ontime_lo;
                3:       dt = regs_now.ontime_hi;
                4:       dt = regs_now.valid_lo - 1;
                5:       dt = regs_now.valid_hi + 1;
                6:       dt = regs_now.ontime_lo - 1;
                default: dt = regs_now.ontime_hi + 1;
            endcase
        end else begin
            dt = $urandom_range(40000, 0);
        end
        spread = $urandom_range(99, 0);
        if (spread < 60)
            dc = regs_now.target + 16'($urandom_range(6, 0)) - 16'd3;
        else if (spread < 88)
            dc = regs_now.target + 16'($urandom_range(400, 0)) - 16'd200;
        else
            dc = 16'($urandom);
        send_step(dt, dc);
    endtask

    task automatic run_events(input int n);
        for (int k = 0; k < n; k++)
            send_frame_event();
    endtask

    // stop offering words until every word has come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (owed == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // upper bits of the 16-bit registers carry junk; the block must mask them
    task automatic program_regs(input t_cfg c);
        cfg_write(CFG_TARGET,    {16'($urandom), c.target});
        cfg_write(CFG_VALID_LO,  c.valid_lo);
        cfg_write(CFG_VALID_HI,  c.valid_hi);
        cfg_write(CFG_ONTIME_LO, c.ontime_lo);
        cfg_write(CFG_ONTIME_HI, c.ontime_hi);
        cfg_write(CFG_GAIN_P,    {16'($urandom), c.gain_p});
        cfg_write(CFG_GAIN_I,    {16'($urandom), c.gain_i});
        cfg_write(CFG_GAIN_D,    {16'($urandom), c.gain_d});
        i_cfg_we <= 1'b0;
        regs_now = c;
    endtask

    // output side: random stalls, calm stretches, and long hold-offs on request
    initial begin : rx_side
        int holds_done, stall, beat;
        bit steady;
        holds_done = 0;
        stall      = 0;
        beat       = 0;
        steady     = 1'b0;
        forever begin
            @(posedge i_clk);
            beat++;
            if (beat % 160 == 0)
                steady = ($urandom_range(3, 0) == 0);
            if (hold_reqs != holds_done) begin
                holds_done++;
                i_ready <= 1'b0;
                for (int n = 1; n < RX_HOLD; n++)
                    @(posedge i_clk);
            end else if (stall > 0) begin
                i_ready <= 1'b0;
                stall--;
            end else begin
                i_ready <= 1'b1;
                if (!steady && $urandom_range(2, 0) == 0)
                    stall = pick_gap();
            end
        end
    end

    initial begin : stimulus
        t_cfg c;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: window edges, clamps, zero step and stamp wrap
        send_word(32'd12500, 16'd3072);
        send_step(32'd12463, 16'd3077);
        send_step(32'd12537, 16'd3067);
        send_step(32'd12462, 16'd3072);
        send_step(32'd12538, 16'd3072);
        send_step(32'd11875, 16'd3000);
        send_step(32'd13125, 16'd3100);
        send_step(32'd11874, 16'd3072);
        send_step(32'd13126, 16'd3072);
        send_step(32'd12500, 16'd3072);
        send_step(32'd12500, 16'd0);
        send_step(32'd12500, 16'd0);
        send_step(32'd12500, 16'hFFFF);
        send_step(32'd12500, 16'hFFFF);
        send_step(32'd0, 16'd0);
        send_word(32'hFFFF_FFFF, 16'hFFFF);
        send_step(32'd12500, 16'd3072);
        send_word(32'hFFFF_E000, 16'hF800);
        send_step(32'd12500, 16'd3080);
        send_step(32'd12490, 16'd3060);
        send_word(32'd0, 16'd0);
        send_word(32'd12500, 16'd3072);
        drain();

        // defaults, with the output held off while words keep coming
        run_events(60);
        hold_reqs++;
        tx_gapless = 1'b1;
        run_events(40);
        tx_gapless = 1'b0;
        run_events(80);
        drain();

        // moderate random windows and P and I gains, fully random D gain
        c.target    = 16'($urandom_range(5000, 1000));
        c.valid_lo  = $urandom_range(12000, 9000);
        c.valid_hi  = c.valid_lo + $urandom_range(3000, 0);
        c.ontime_lo = c.valid_lo + $urandom_range(c.valid_hi - c.valid_lo, 0);
        c.ontime_hi = c.ontime_lo + $urandom_range(400, 0);
        c.gain_p    = 16'($urandom_range(20000, 0));
        c.gain_i    = 16'($urandom_range(400, 0) - 200);
        c.gain_d    = 16'($urandom);
        program_regs(c);
        run_events(180);
        drain();

        // widest windows, largest target, extreme gains; unused indexes get junk
        for (int k = 8; k < 16; k++)
            cfg_write(CFG_IDX_W'(k), $urandom);
        c.target    = 16'hFFFF;
        c.valid_lo  = 32'h0000_0000;
        c.valid_hi  = 32'hFFFF_FFFF;
        c.ontime_lo = 32'h0000_0000;
        c.ontime_hi = 32'hFFFF_FFFF;
        c.gain_p    = 16'sh8000;
        c.gain_i    = 16'sh7FFF;
        c.gain_d    = 16'sh8000;
        program_regs(c);
        run_events(150);
        drain();

        // zero target, opposite extreme gains, reset windows
        c = CFG_RESET;
        c.target = 16'd0;
        c.gain_p = 16'sh7FFF;
        c.gain_i = 16'sh8000;
        c.gain_d = 16'sh7FFF;
        program_regs(c);
        run_events(150);
        drain();

        // inverted validity window: every step clears the loop
        c = CFG_RESET;
        c.valid_lo = 32'd13125;
        c.valid_hi = 32'd11875;
        program_regs(c);
        run_events(40);
        drain();

        // inverted on-time window: valid steps only hold
        c = CFG_RESET;
        c.ontime_lo = 32'd12537;
        c.ontime_hi = 32'd12463;
        c.gain_d    = 16'sd300;
        program_regs(c);
        run_events(60);
        drain();

        // windows pinned at the top of the range
        c = CFG_RESET;
        c.valid_lo  = 32'hFFFF_FFFF;
        c.valid_hi  = 32'hFFFF_FFFF;
        c.ontime_lo = 32'hFFFF_FFFF;
        c.ontime_hi = 32'hFFFF_FFFF;
        program_regs(c);
        run_events(50);
        drain();

        // fully random gains and target, half of it back to back
        c = CFG_RESET;
        c.target = 16'($urandom);
        c.gain_p = 16'($urandom);
        c.gain_i = 16'($urandom);
        c.gain_d = 16'($urandom);
        program_regs(c);
        tx_gapless = 1'b1;
        run_events(100);
        tx_gapless = 1'b0;
        run_events(100);
        drain();

        // reset values written back explicitly
        program_regs(CFG_RESET);
        run_events(150);
        drain();

        if (fail_cnt == 0 && owed == 0)
            $display("sof_locked_pll_pid_tuner_top_tb OK");
        else
            $display("sof_locked_pll_pid_tuner_top_tb NOT OK");
        $finish;
    end

endmodule
